[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, sizes and codes of the free-block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Map geometry. WORD_BITS is a power of two.
    localparam int NUM_BLOCKS = 1024 * 16;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int HINT_W     = $clog2(MAP_WORDS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int LAST_BITS  = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;

    // Payload field widths
    localparam int OP_W  = 2;
    localparam int IDX_W = 14;
    localparam int NUM_W = 14;
    localparam int ST_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t FULL_WORD = {WORD_BITS{1'b1}};
    // bits past the last block are stored clear so they are never handed out
    localparam word_t LAST_WORD = FULL_WORD >> (WORD_BITS - LAST_BITS);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] block_index;
    } in_t;

    typedef struct packed {
        logic [NUM_W-1:0] block_number;
        logic [ST_W-1:0]  status;
    } out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_DONE
    } state_t;

    // Position of the lowest set bit (zero for an empty word).
    function automatic logic [BIT_W-1:0] lowest_bit(input word_t w);
        word_t            iso;
        logic [BIT_W-1:0] pos;
        iso = w & (~w + word_t'(1));
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (iso[i]) begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block allocator over a bitmap held in one block RAM.
// ----------------------------------------------------------------------------
// One bit per block sits in a 512 x 32 RAM (set = free, block n in word n/32,
// bit n%32). Every input transfer gives exactly one result transfer. After
// reset the block runs a clearing pass, writing every word free, and holds
// s_ready low meanwhile. Allocate reads words one per cycle from a low-water
// mark (no free block below it) and takes the lowest set bit, reading 1 to
// 512 words before the result register; once a scan has found the map full,
// further allocates skip the scan until an in-range free or a format. Free is
// a read-modify-write of one word. Format repeats the clearing pass. Unused
// op code 3 and an out of range free go straight to completion. A finished
// result waits in the output register while the next transfer is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bba_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bba_pkg::out_t      m_data
);

    localparam int AW = bba_pkg::ADDR_W;
    localparam int HW = bba_pkg::HINT_W;
    localparam int BW = bba_pkg::BIT_W;
    localparam int NW = bba_pkg::NUM_W;

    bba_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;     // scan / clear word pointer
    logic [HW-1:0]   hint_reg, hint_next;   // low-water mark, MAP_WORDS = full
    logic            fmt_reg, fmt_next;     // clear pass owes a result
    bba_pkg::in_t    req_reg, req_next;
    bba_pkg::out_t   res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    bba_pkg::out_t   m_data_reg, m_data_next;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    bba_pkg::word_t      ram_wdata;
    logic [AW-1:0]       ram_raddr;
    bba_pkg::word_t      ram_rdata;

    logic            accept;
    logic [AW-1:0]   in_word;
    logic            in_range;
    logic [AW-1:0]   req_word;
    logic [BW-1:0]   req_bit;
    logic [BW-1:0]   found_bit;
    logic            word_zero;
    logic            last_ptr;
    logic            out_free;
    logic            hint_full;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_BITS),
        .DEPTH (bba_pkg::MAP_WORDS)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = s_valid && s_ready;
    assign in_word   = AW'(s_data.block_index >> BW);
    assign in_range  = 32'(s_data.block_index) < bba_pkg::NUM_BLOCKS;
    assign req_word  = AW'(req_reg.block_index >> BW);
    assign req_bit   = BW'(req_reg.block_index);
    assign found_bit = bba_pkg::lowest_bit(ram_rdata);
    assign word_zero = (ram_rdata == '0);
    assign last_ptr  = (ptr_reg == AW'(bba_pkg::MAP_WORDS - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign hint_full = (hint_reg == HW'(bba_pkg::MAP_WORDS));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_CLEAR: begin
                if (last_ptr) begin
                    state_next = fmt_reg ? bba_pkg::S_DONE : bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (accept) begin
                    case (s_data.op)
                        bba_pkg::OP_ALLOC: begin
                            state_next = hint_full ? bba_pkg::S_DONE : bba_pkg::S_SCAN;
                        end
                        bba_pkg::OP_FREE: begin
                            state_next = in_range ? bba_pkg::S_FREE_RD : bba_pkg::S_DONE;
                        end
                        bba_pkg::OP_FORMAT: begin
                            state_next = bba_pkg::S_CLEAR;
                        end
                        default: begin
                            state_next = bba_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bba_pkg::S_SCAN: begin
                if (!word_zero || last_ptr) begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_FREE_RD: begin
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::S_CLEAR;
            end
        endcase
    end

    // Handshake and RAM controls
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = bba_pkg::FULL_WORD;
        ram_raddr = ptr_reg + AW'(1);
        case (state_reg)
            bba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = last_ptr ? bba_pkg::LAST_WORD : bba_pkg::FULL_WORD;
            end
            bba_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = (s_data.op == bba_pkg::OP_FREE) ? in_word : AW'(hint_reg);
            end
            bba_pkg::S_SCAN: begin
                // next word is read ahead; unused once a bit is found
                ram_we    = !word_zero;
                ram_wdata = ram_rdata & ~(bba_pkg::word_t'(1) << found_bit);
            end
            bba_pkg::S_FREE_RD: begin
                ram_we    = 1'b1;
                ram_waddr = req_word;
                ram_wdata = ram_rdata | (bba_pkg::word_t'(1) << req_bit);
            end
            bba_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        ptr_next     = ptr_reg;
        hint_next    = hint_reg;
        fmt_next     = fmt_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            bba_pkg::S_CLEAR: begin
                ptr_next = ptr_reg + AW'(1);
                if (last_ptr) begin
                    ptr_next  = '0;
                    hint_next = '0;
                    fmt_next  = 1'b0;
                    res_next  = '{block_number: '0, status: bba_pkg::ST_OK};
                end
            end
            bba_pkg::S_IDLE: begin
                if (accept) begin
                    req_next = s_data;
                    res_next = '{block_number: '0, status: bba_pkg::ST_OK};
                    case (s_data.op)
                        bba_pkg::OP_ALLOC: begin
                            if (hint_full) begin
                                res_next.status = bba_pkg::ST_FULL;
                            end else begin
                                ptr_next = AW'(hint_reg);
                            end
                        end
                        bba_pkg::OP_FREE: begin
                            if (!in_range) begin
                                res_next.status = bba_pkg::ST_RANGE;
                            end
                        end
                        bba_pkg::OP_FORMAT: begin
                            ptr_next = '0;
                            fmt_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bba_pkg::S_SCAN: begin
                if (!word_zero) begin
                    res_next.block_number = NW'((32'(ptr_reg) << BW) | 32'(found_bit));
                    hint_next             = HW'(ptr_reg);
                end else if (last_ptr) begin
                    res_next.status = bba_pkg::ST_FULL;
                    hint_next       = HW'(bba_pkg::MAP_WORDS);
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            bba_pkg::S_FREE_RD: begin
                if (HW'(req_word) < hint_reg) begin
                    hint_next = HW'(req_word);
                end
            end
            bba_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bba_pkg::S_CLEAR;
            ptr_reg     <= '0;
            hint_reg    <= '0;
            fmt_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            hint_reg    <= hint_next;
            fmt_reg     <= fmt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_hint_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= HW'(bba_pkg::MAP_WORDS))
        else $error("low-water mark beyond map");

    a_scan_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bba_pkg::S_SCAN) && ram_we |-> ram_rdata != '0)
        else $error("allocate wrote back an empty word");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == bba_pkg::S_DONE)
        else $error("result raised outside completion");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != bba_pkg::S_IDLE)
        else $error("accepted transfer left no work");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status != bba_pkg::ST_OK)
            |-> m_data_reg.block_number == '0)
        else $error("failed request returned a block number");

endmodule

`default_nettype wire
